// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the checksum engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== design/rs1024_pkg.sv =====
// ----------------------------------------------------------------------------
// rs1024_pkg
// Types, generator constants and the customized start value of the checksum.
// ----------------------------------------------------------------------------
package rs1024_pkg;

  // One symbol of GF(1024) and the three-symbol accumulator.
  localparam int unsigned SYM_W     = 10;
  localparam int unsigned NUM_CELLS = 3;
  localparam int unsigned ACC_W     = SYM_W * NUM_CELLS;
  localparam int unsigned GEN_NUM   = 10;

  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [ACC_W-1:0] acc_t;
  typedef logic [GEN_NUM-1:0][SYM_W-1:0] gen_slice_t;

  // Generator constants, selected by the bits of the top symbol.
  localparam logic [GEN_NUM-1:0][ACC_W-1:0] GEN = {
    30'h03f3f120, 30'h21b1f890, 30'h3090fc48, 30'h38086c24, 30'h1c0c2412,
    30'h0e0e0009, 30'h07070200, 30'h03838100, 30'h01c1c080, 30'h00e0e040
  };

  // Control that the sequencer hands to the cell row.
  typedef struct packed {
    logic fold;
    logic restart;
    sym_t feed;
  } chain_ctrl_t;

  // One fold step, used only to work out the start value at elaboration.
  function automatic acc_t fold_ref(acc_t acc, sym_t w);
    acc_t nxt;
    nxt = {acc[ACC_W-SYM_W-1:0], w};
    for (int k = 0; k < GEN_NUM; k++) begin
      if (acc[ACC_W-SYM_W+k]) begin
        nxt = nxt ^ GEN[k];
      end
    end
    return nxt;
  endfunction

  // Start value 1 followed by the customization string.
  function automatic acc_t start_calc();
    sym_t cust [6];
    acc_t acc;
    cust[0] = sym_t'(8'h73);
    cust[1] = sym_t'(8'h68);
    cust[2] = sym_t'(8'h61);
    cust[3] = sym_t'(8'h6d);
    cust[4] = sym_t'(8'h69);
    cust[5] = sym_t'(8'h72);
    acc = acc_t'(1);
    for (int k = 0; k < 6; k++) begin
      acc = fold_ref(acc, cust[k]);
    end
    return acc;
  endfunction

  localparam acc_t START_VALUE = start_calc();

endpackage

// ===== design/rs1024_cell.sv =====
// ----------------------------------------------------------------------------
// rs1024_cell
// One symbol of the accumulator: takes the symbol below and adds the
// generator share chosen by the broadcast top symbol.
// ----------------------------------------------------------------------------
module rs1024_cell
  import rs1024_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  chain_ctrl_t ctrl,
  input  sym_t        start_sym,
  input  gen_slice_t  gen_slice,
  input  sym_t        top_sym,
  input  sym_t        shift_in,
  output sym_t        sym,
  output sym_t        sym_next
);

  // Shifted-in symbol plus this cell's share of each selected generator.
  always_comb begin
    sym_next = shift_in;
    for (int k = 0; k < GEN_NUM; k++) begin
      if (top_sym[k]) begin
        sym_next = sym_next ^ gen_slice[k];
      end
    end
  end

  // Symbol register; restart returns it to its share of the start value.
  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      sym <= start_sym;
    end else if (ctrl.fold) begin
      sym <= sym_next;
    end
  end

endmodule

// ===== design/rs1024_chain.sv =====
// ----------------------------------------------------------------------------
// rs1024_chain
// Row of three symbol cells that together hold the 30-bit accumulator.
// ----------------------------------------------------------------------------
module rs1024_chain
  import rs1024_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  chain_ctrl_t ctrl,
  output acc_t        acc,
  output acc_t        acc_next
);

  sym_t top_sym;

  // The most significant symbol steers every cell.
  assign top_sym = acc[ACC_W-1 -: SYM_W];

  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    gen_slice_t slice;
    sym_t       shift_in;

    // This cell's part of each generator constant.
    for (genvar j = 0; j < GEN_NUM; j++) begin : g_gen
      assign slice[j] = GEN[j][c*SYM_W +: SYM_W];
    end

    // The lowest cell takes the new word, the others their lower neighbor.
    if (c == 0) begin : g_low
      assign shift_in = ctrl.feed;
    end else begin : g_up
      assign shift_in = acc[(c-1)*SYM_W +: SYM_W];
    end

    rs1024_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .start_sym (START_VALUE[c*SYM_W +: SYM_W]),
      .gen_slice (slice),
      .top_sym   (top_sym),
      .shift_in  (shift_in),
      .sym       (acc[c*SYM_W +: SYM_W]),
      .sym_next  (acc_next[c*SYM_W +: SYM_W])
    );
  end

endmodule

// ===== design/rs1024_checksum_engine.sv =====
// ----------------------------------------------------------------------------
// rs1024_checksum_engine
// Streaming RS1024 checksum over GF(1024) with customized start value.
// ----------------------------------------------------------------------------
// Usage: message words enter on the input channel (in_valid, in_stall, word,
// last), one transaction per word. Results leave on the output channel
// (out_valid, out_stall, check_word, valid_res, final_res).
// A word that is not last is folded into the accumulator, so words stream
// at one per cycle while input is not stalled, and produce no result.
// Verify mode: the last word yields one result on the next cycle, valid_res
// set when the accumulator equals 1.
// Generate mode: the last word starts three zero-word folds through the cell
// row, during which input is stalled; the three checksum words, most
// significant first, are loaded into the output queue by the final zero fold,
// and final_res marks the third.
// The results wait in a three-entry output queue, so new words are taken
// while the receiver stalls; only a verify last word, or the final zero fold
// of a generate message, waits for the queue to drain.
// Reset (rst, synchronous) loads the customized start value into the cells,
// clears the queue and selects generate mode. verify_mode is to be written
// through cfg_we and cfg_wdata while the block is idle; the block does not check.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rs1024_checksum_engine
  import rs1024_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  input  logic in_valid,
  output logic in_stall,
  input  sym_t word,
  input  logic last,
  output logic out_valid,
  input  logic out_stall,
  output sym_t check_word,
  output logic valid_res,
  output logic final_res
);

  logic        verify_mode;
  logic [1:0]  flush_cnt;
  logic [1:0]  flush_cnt_next;
  logic [1:0]  q_count;
  logic [1:0]  q_count_next;
  logic        q_flag;
  logic        q_flag_next;
  sym_t        q_word [NUM_CELLS];
  sym_t        q_word_next [NUM_CELLS];
  logic        in_take;
  logic        out_pop;
  logic        load_gen;
  logic        load_ver;
  chain_ctrl_t ctrl;
  acc_t        acc;
  acc_t        acc_next;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      verify_mode <= 1'b0;
    end else if (cfg_we) begin
      verify_mode <= cfg_wdata;
    end
  end

  // Handshake: stall while flushing, and hold a verify last word until the
  // queue is empty.
  assign in_stall = (flush_cnt != 2'd0) || (last && verify_mode && (q_count != 2'd0));
  assign in_take  = in_valid && !in_stall;
  assign out_pop  = out_valid && !out_stall;

  // Queue loads: the final zero fold in generate mode, or a verify last word.
  assign load_gen = (flush_cnt == 2'd1) && (q_count == 2'd0);
  assign load_ver = in_take && last && verify_mode;

  // Cell row control.
  always_comb begin
    ctrl.feed    = (flush_cnt == 2'd0) ? word : '0;
    ctrl.restart = load_gen || load_ver;
    ctrl.fold    = in_take || ((flush_cnt != 2'd0) && !((flush_cnt == 2'd1) &&
                   (q_count != 2'd0)));
  end

  rs1024_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .acc      (acc),
    .acc_next (acc_next)
  );

  // Flush counter for the three zero folds after a generate last word.
  always_comb begin
    flush_cnt_next = flush_cnt;
    priority if (in_take && last && !verify_mode) begin
      flush_cnt_next = 2'd3;
    end else if (flush_cnt > 2'd1) begin
      flush_cnt_next = flush_cnt - 2'd1;
    end else if (load_gen) begin
      flush_cnt_next = 2'd0;
    end else begin
      flush_cnt_next = flush_cnt;
    end
  end

  // Output queue: head at entry 0, shifts on each output transaction.
  always_comb begin
    q_count_next = q_count;
    q_flag_next  = q_flag;
    for (int k = 0; k < NUM_CELLS; k++) begin
      q_word_next[k] = q_word[k];
    end
    priority if (load_gen) begin
      q_count_next   = 2'd3;
      q_flag_next    = 1'b0;
      q_word_next[0] = acc_next[ACC_W-1 -: SYM_W];
      q_word_next[1] = acc_next[SYM_W +: SYM_W];
      q_word_next[2] = acc_next[SYM_W-1:0] ^ sym_t'(1);
    end else if (load_ver) begin
      q_count_next   = 2'd1;
      q_flag_next    = (acc_next == acc_t'(1));
      q_word_next[0] = '0;
    end else if (out_pop) begin
      q_count_next = q_count - 2'd1;
      for (int k = 0; k < NUM_CELLS - 1; k++) begin
        q_word_next[k] = q_word[k+1];
      end
    end else begin
      q_count_next = q_count;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      flush_cnt <= 2'd0;
      q_count   <= 2'd0;
    end else begin
      flush_cnt <= flush_cnt_next;
      q_count   <= q_count_next;
    end
  end

  // Queue payload.
  always_ff @(posedge clk) begin
    q_flag <= q_flag_next;
    for (int k = 0; k < NUM_CELLS; k++) begin
      q_word[k] <= q_word_next[k];
    end
  end

  // Result fields come straight from the queue head.
  assign out_valid  = (q_count != 2'd0);
  assign check_word = q_word[0];
  assign valid_res  = q_flag;
  assign final_res  = (q_count == 2'd1);

  // Checks on the sequencing.
  `CHK_IMPLY(a_flush_stalls, flush_cnt != 2'd0, in_stall)
  `CHK_IMPLY(a_load_empty, load_gen || load_ver, q_count == 2'd0)
  `CHK_IMPLY(a_verify_single, out_valid && q_flag, q_count == 2'd1)
  `CHK_NEXT(a_restart_value, ctrl.restart, acc == START_VALUE)

endmodule

// ===== test/rs1024_checksum_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs1024_checksum_engine_tb
// Self-checking bench for the streaming RS1024 checksum engine. Words go in
// through the input channel and a local model of the GF(1024) accumulator
// predicts the checksum words or the verify flag of every message. Directed
// messages cover the extremes and mode handling. Random messages follow, most
// of them valid codewords in verify mode, with and without random idling.
// ----------------------------------------------------------------------------
module rs1024_checksum_engine_tb
  import rs1024_pkg::*;
();

  // Generator polynomial constants, index k selected by bit k of the top symbol.
  localparam logic [9:0][29:0] POLY_TAB = {
    30'h03f3f120, 30'h21b1f890, 30'h3090fc48, 30'h38086c24, 30'h1c0c2412,
    30'h0e0e0009, 30'h07070200, 30'h03838100, 30'h01c1c080, 30'h00e0e040
  };
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic MODE_GENERATE = 1'b0;
  localparam logic MODE_VERIFY = 1'b1;

  typedef struct packed {
    sym_t check_word;
    logic valid_res;
    logic final_res;
  } engine_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sym_t word = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  sym_t check_word;
  logic valid_res;
  logic final_res;

  // Model state and bookkeeping.
  logic [29:0] start_acc;
  logic [29:0] model_acc;
  logic model_verify;
  engine_out_t results_owed[$];
  engine_out_t owed_head;
  sym_t msg_buf[$];
  int item_count = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit tx_idle_on = 1'b1;
  bit rx_stall_on = 1'b1;

  rs1024_checksum_engine DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .word(word),
    .last(last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .check_word(check_word),
    .valid_res(valid_res),
    .final_res(final_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // One polynomial-modulus step: shift the accumulator up a symbol and reduce.
  function automatic logic [29:0] fold_symbol(logic [29:0] acc, sym_t w);
    logic [29:0] nxt;
    nxt = {acc[19:0], w};
    for (int k = 0; k < 10; k++) begin
      if (acc[20+k]) begin
        nxt = nxt ^ POLY_TAB[k];
      end
    end
    return nxt;
  endfunction

  // Accumulator after the value 1 and the customization string "shamir".
  function automatic logic [29:0] customized_start();
    logic [29:0] acc;
    acc = 30'd1;
    acc = fold_symbol(acc, sym_t'(8'h73));
    acc = fold_symbol(acc, sym_t'(8'h68));
    acc = fold_symbol(acc, sym_t'(8'h61));
    acc = fold_symbol(acc, sym_t'(8'h6d));
    acc = fold_symbol(acc, sym_t'(8'h69));
    acc = fold_symbol(acc, sym_t'(8'h72));
    return acc;
  endfunction

  // Three checksum symbols that make the message in msg_buf a valid codeword.
  function automatic logic [29:0] checksum_of_buf();
    logic [29:0] acc;
    acc = start_acc;
    foreach (msg_buf[i]) begin
      acc = fold_symbol(acc, msg_buf[i]);
    end
    repeat (3) acc = fold_symbol(acc, '0);
    return acc ^ 30'd1;
  endfunction

  // Advances the model by one accepted word and queues the results it owes.
  task automatic advance_model(input sym_t w, input logic l);
    engine_out_t res;
    model_acc = fold_symbol(model_acc, w);
    if (l) begin
      if (model_verify == MODE_VERIFY) begin
        res.check_word = '0;
        res.valid_res = (model_acc == 30'd1);
        res.final_res = 1'b1;
        results_owed.push_back(res);
      end else begin
        repeat (3) model_acc = fold_symbol(model_acc, '0);
        model_acc = model_acc ^ 30'd1;
        for (int k = 0; k < 3; k++) begin
          res.check_word = model_acc[10*(2-k) +: 10];
          res.valid_res = 1'b0;
          res.final_res = (k == 2);
          results_owed.push_back(res);
        end
      end
      model_acc = start_acc;
    end
  endtask

  // Sends one word as a transaction, with an optional idle burst in front.
  task automatic send_word(input sym_t w, input logic l);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    word <= w;
    last <= l;
    do @(posedge clk); while (in_stall);
    advance_model(w, l);
    item_count++;
  endtask

  task automatic send_msg_buf();
    foreach (msg_buf[i]) begin
      send_word(msg_buf[i], i == msg_buf.size() - 1);
    end
  endtask

  // Holds the input channel until every owed result has been received.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed.size() != 0) @(posedge clk);
  endtask

  // Writes the mode register once the engine has gone quiet.
  task automatic write_verify_mode(input logic mode);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_verify = mode;
  endtask

  // Fills msg_buf with a random body, mostly short, sometimes share-sized.
  task automatic fill_random_body();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 33) : $urandom_range(1, 8);
    msg_buf.delete();
    repeat (len) msg_buf.push_back(sym_t'($urandom_range(0, 1023)));
  endtask

  // Appends the three checksum symbols to the body in msg_buf.
  task automatic append_checksum();
    logic [29:0] cs;
    cs = checksum_of_buf();
    msg_buf.push_back(cs[29:20]);
    msg_buf.push_back(cs[19:10]);
    msg_buf.push_back(cs[9:0]);
  endtask

  task automatic report_mismatch(input string what, input engine_out_t exp_r);
    if (mismatch_count < 10) begin
      $display("%s: expected word %03h valid %0b final %0b, got word %03h valid %0b final %0b",
               what, exp_r.check_word, exp_r.valid_res, exp_r.final_res,
               check_word, valid_res, final_res);
    end
    mismatch_count++;
  endtask

  // Compares each result transaction with the oldest owed result.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (results_owed.size() == 0) begin
        report_mismatch("unexpected result", '0);
      end else begin
        owed_head = results_owed.pop_front();
        if (check_word !== owed_head.check_word || valid_res !== owed_head.valid_res ||
            final_res !== owed_head.final_res) begin
          report_mismatch("result mismatch", owed_head);
        end
      end
    end
  end

  // Receiver stalls in random bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (rx_stall_on && !rst && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Generate mode on extreme words and a one-word message.
  task automatic test_generate_directed();
    write_verify_mode(MODE_GENERATE);
    msg_buf = '{10'h000, 10'h3ff, 10'h155, 10'h2aa, 10'h001, 10'h200};
    send_msg_buf();
    send_word(10'h3ff, 1'b1);
  endtask

  // Verify mode on a valid codeword and on the same codeword with a bad symbol.
  task automatic test_verify_directed();
    write_verify_mode(MODE_VERIFY);
    msg_buf = '{10'h3ff, 10'h000};
    append_checksum();
    send_msg_buf();
    msg_buf[1] = msg_buf[1] ^ 10'h200;
    send_msg_buf();
  endtask

  // The mode is taken when the last word arrives, not when the message starts.
  task automatic test_mode_switch_in_message();
    write_verify_mode(MODE_GENERATE);
    msg_buf = '{10'h123};
    append_checksum();
    for (int i = 0; i < 3; i++) send_word(msg_buf[i], 1'b0);
    write_verify_mode(MODE_VERIFY);
    send_word(msg_buf[3], 1'b1);
    send_word(10'h3ff, 1'b0);
    write_verify_mode(MODE_GENERATE);
    send_word(10'h000, 1'b1);
  endtask

  task automatic test_random_generate(input int item_goal);
    write_verify_mode(MODE_GENERATE);
    while (item_count < item_goal) begin
      fill_random_body();
      send_msg_buf();
      if ($urandom_range(0, 15) == 0) wait_results_drained();
    end
  endtask

  // Mostly valid codewords; the rest carry a corrupted symbol.
  task automatic test_random_verify(input int item_goal);
    int idx;
    write_verify_mode(MODE_VERIFY);
    while (item_count < item_goal) begin
      fill_random_body();
      append_checksum();
      if ($urandom_range(0, 3) == 0) begin
        idx = $urandom_range(0, msg_buf.size() - 1);
        msg_buf[idx] = msg_buf[idx] ^ sym_t'($urandom_range(1, 1023));
      end
      send_msg_buf();
    end
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_steady_stream(input int item_goal);
    tx_idle_on = 1'b0;
    rx_stall_on = 1'b0;
    test_random_generate(item_count + (item_goal - item_count) / 2);
    wait_results_drained();
    test_random_verify(item_goal);
  endtask

  initial begin
    start_acc = customized_start();
    model_acc = start_acc;
    model_verify = MODE_GENERATE;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_generate_directed();
    test_verify_directed();
    test_mode_switch_in_message();
    test_random_generate(140);
    test_random_verify(300);
    test_steady_stream(360);
    wait_results_drained();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0 && results_owed.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
